>>> src/bmrf_pkg.sv
package bmrf_pkg;

    localparam int unsigned WORD_COUNT = 37;
    localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);

    localparam logic [3:0] K_READ       = 4'd0;
    localparam logic [3:0] K_WRITE      = 4'd1;
    localparam logic [3:0] K_INCR       = 4'd2;
    localparam logic [3:0] K_SET_MODE   = 4'd3;
    localparam logic [3:0] K_REVERT     = 4'd4;
    localparam logic [3:0] K_SET_FLAGS  = 4'd5;
    localparam logic [3:0] K_WR_STATUS  = 4'd6;
    localparam logic [3:0] K_RD_SAVED   = 4'd7;
    localparam logic [3:0] K_RESET      = 4'd8;

    localparam logic [4:0] FIQ_MODE = 5'h11;
    localparam logic [4:0] IRQ_MODE = 5'h12;
    localparam logic [4:0] SVC_MODE = 5'h13;
    localparam logic [4:0] SYS_MODE = 5'h1F;

    localparam logic [ADDR_W-1:0] SLOT_SP       = ADDR_W'(13);
    localparam logic [ADDR_W-1:0] SLOT_PC       = ADDR_W'(15);
    localparam logic [ADDR_W-1:0] SLOT_SPSR_SVC = ADDR_W'(19);
    localparam logic [ADDR_W-1:0] SLOT_SPSR_IRQ = ADDR_W'(28);
    localparam logic [ADDR_W-1:0] SLOT_SPSR_FIQ = ADDR_W'(36);

    localparam logic [31:0] STACK_RESET  = 32'h0000_7000;
    localparam logic [31:0] STATUS_RESET = 32'h0000_001F;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  reg_index;
        logic [31:0] value;
        logic [4:0]  new_mode;
        logic        save_status;
        logic        post_increment;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] status_word;
        logic        fiq_disabled;
        logic        irq_disabled;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic rd;
        logic ex;
    } t_cmd;

    function automatic logic [ADDR_W-1:0] slot_of(input logic [4:0] mode,
                                                 input logic [3:0] r);
        logic [ADDR_W-1:0] s;
        s = ADDR_W'(r);
        if (mode == SVC_MODE && (r == 4'd13 || r == 4'd14)) begin
            s = ADDR_W'(r) + ADDR_W'(4);
        end else if (mode == IRQ_MODE && (r == 4'd13 || r == 4'd14)) begin
            s = ADDR_W'(r) + ADDR_W'(13);
        end else if (mode == FIQ_MODE && r >= 4'd8 && r <= 4'd14) begin
            s = ADDR_W'(r) + ADDR_W'(21);
        end
        return s;
    endfunction

    function automatic logic has_saved(input logic [4:0] mode);
        return mode == SVC_MODE || mode == IRQ_MODE || mode == FIQ_MODE;
    endfunction

    function automatic logic [ADDR_W-1:0] saved_slot(input logic [4:0] mode);
        logic [ADDR_W-1:0] s;
        s = SLOT_SPSR_SVC;
        if (mode == IRQ_MODE) begin
            s = SLOT_SPSR_IRQ;
        end else if (mode == FIQ_MODE) begin
            s = SLOT_SPSR_FIQ;
        end
        return s;
    endfunction

endpackage

>>> src/banked_mode_register_file.sv
// Banked register file with current and saved program status words.
// The input channel carries one access per beat: a read, write or
// increment of r0 to r15 remapped by the current mode, a mode change,
// a revert, a flag or status write, a saved status read, or a soft reset.
// The output channel returns one beat per access with the read data and
// the status word after the access.
// An accepted beat is registered; the read state then reads the word store,
// and the execute state computes the result, writes it back and registers
// the output, which the output state presents until it is taken. One access
// is in flight at a time; the store is read and written in separate states.
// While a result waits, the input is not ready and the result holds.
// After reset r13 reads 0x7000, the status word is 0x1F and all other
// words read zero. A soft reset beat does the same and loads r15 with
// the beat's value; it takes effect at once, with no clearing pass.
module banked_mode_register_file (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bmrf_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bmrf_pkg::t_out_item  o_out_data
);
    import bmrf_pkg::*;

    t_cmd w_cmd;

    bmrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    bmrf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_in_data),
        .o_item  (o_out_data)
    );

endmodule

>>> src/bmrf_ctrl.sv
module bmrf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bmrf_pkg::t_cmd  o_cmd
);
    import bmrf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EX   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        o_cmd.rd   = (r_state == S_RD);
        o_cmd.ex   = (r_state == S_EX);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD:   n_state = S_EX;
            S_EX:   n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_RD)
        else $error("accepted beat did not start the read cycle");

    a_exec_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ex |=> o_out_valid)
        else $error("executed beat was not presented");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result waits");

endmodule

>>> src/bmrf_dp.sv
module bmrf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bmrf_pkg::t_cmd       i_cmd,
    input  bmrf_pkg::t_in_item   i_item,
    output bmrf_pkg::t_out_item  o_item
);
    import bmrf_pkg::*;

    logic [31:0]           mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] r_valid;
    t_in_item              r_item;
    logic [31:0]           r_cpsr;
    logic [31:0]           n_cpsr;
    logic [ADDR_W-1:0]     r_rd_addr;
    logic [31:0]           r_rdata;
    logic                  r_rd_valid;
    t_out_item             r_out;

    logic [4:0]        w_mode;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [31:0]       w_word;
    logic [31:0]       w_sum;
    logic [31:0]       w_rd_out;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [31:0]       w_wr_data;
    logic              w_reset;

    assign w_mode = r_cpsr[4:0];

    always_comb begin
        if (r_item.kind == K_REVERT || r_item.kind == K_RD_SAVED) begin
            w_rd_addr = saved_slot(w_mode);
        end else begin
            w_rd_addr = slot_of(w_mode, r_item.reg_index);
        end
    end

    always_comb begin
        if (r_rd_valid) begin
            w_word = r_rdata;
        end else if (r_rd_addr == SLOT_SP) begin
            w_word = STACK_RESET;
        end else begin
            w_word = '0;
        end
    end

    assign w_sum = w_word + r_item.value;

    always_comb begin
        n_cpsr    = r_cpsr;
        w_rd_out  = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_rd_addr;
        w_wr_data = r_item.value;
        w_reset   = 1'b0;
        unique case (r_item.kind)
            K_READ: w_rd_out = w_word;
            K_WRITE: w_wr_en = 1'b1;
            K_INCR: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_sum;
                w_rd_out  = r_item.post_increment ? w_word : w_sum;
            end
            K_SET_MODE: begin
                w_wr_en   = r_item.save_status && has_saved(r_item.new_mode);
                w_wr_addr = saved_slot(r_item.new_mode);
                w_wr_data = r_cpsr;
                n_cpsr    = {r_cpsr[31:5], r_item.new_mode};
            end
            K_REVERT: begin
                if (has_saved(w_mode)) begin
                    n_cpsr = w_word;
                end
            end
            K_SET_FLAGS: begin
                n_cpsr = {r_item.flag_n, r_item.flag_z, r_item.flag_c, r_item.flag_v,
                          r_cpsr[27:0]};
            end
            K_WR_STATUS: n_cpsr = r_item.value;
            K_RD_SAVED: begin
                if (has_saved(w_mode)) begin
                    w_rd_out = w_word;
                end
            end
            K_RESET: begin
                w_reset   = 1'b1;
                w_wr_en   = 1'b1;
                w_wr_addr = SLOT_PC;
                n_cpsr    = STATUS_RESET;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ex && w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.rd) begin
            r_rd_addr  <= w_rd_addr;
            r_rd_valid <= r_valid[w_rd_addr];
        end
        if (i_cmd.ex) begin
            r_out.read_data    <= w_rd_out;
            r_out.status_word  <= n_cpsr;
            r_out.fiq_disabled <= n_cpsr[6];
            r_out.irq_disabled <= n_cpsr[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cpsr  <= STATUS_RESET;
        end else if (i_cmd.ex) begin
            r_cpsr <= n_cpsr;
            if (w_reset) begin
                r_valid <= WORD_COUNT'(1) << SLOT_PC;
            end else if (w_wr_en) begin
                r_valid <= r_valid | (WORD_COUNT'(1) << w_wr_addr);
            end
        end
    end

    assign o_item = r_out;

    a_reset_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ex && r_item.kind == K_RESET
        |=> r_valid == (WORD_COUNT'(1) << SLOT_PC) && r_cpsr == STATUS_RESET)
        else $error("reset beat left stale words or status");

    a_status_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ex && r_item.kind == K_WR_STATUS |=> r_cpsr == $past(r_item.value))
        else $error("status write lost");

    a_status_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ex |=> r_out.status_word == r_cpsr)
        else $error("presented status differs from held status");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import bmrf_pkg::*;

    localparam int STATUS_SLOT = 16;
    localparam int RANDOM_BEATS = 600;
    localparam logic [3:0] K_SPARE_LO = 4'd9;
    localparam logic [3:0] K_SPARE_HI = 4'd15;

    typedef struct {
        t_in_item  beat;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_data;

    logic [31:0]   bank [0:WORD_COUNT-1];
    t_out_item     pending_results [$];
    t_directed_row directed_rows [$];
    int unsigned   mismatches;
    bit            calm;

    banked_mode_register_file uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void clear_bank(input logic [31:0] entry);
        for (int i = 0; i < WORD_COUNT; i++) begin
            bank[i] = '0;
        end
        bank[STATUS_SLOT] = STATUS_RESET;
        bank[SLOT_PC]     = entry;
        bank[SLOT_SP]     = STACK_RESET;
    endfunction

    function automatic int bank_slot(input logic [4:0] mode, input logic [3:0] r);
        int s;
        s = int'(r);
        if (mode == SVC_MODE && (s == 13 || s == 14)) begin
            s = s + 4;
        end else if (mode == IRQ_MODE && (s == 13 || s == 14)) begin
            s = s + 13;
        end else if (mode == FIQ_MODE && s >= 8 && s <= 14) begin
            s = s + 21;
        end
        return s;
    endfunction

    function automatic int saved_index(input logic [4:0] mode);
        int s;
        s = -1;
        if (mode == SVC_MODE) begin
            s = int'(SLOT_SPSR_SVC);
        end else if (mode == IRQ_MODE) begin
            s = int'(SLOT_SPSR_IRQ);
        end else if (mode == FIQ_MODE) begin
            s = int'(SLOT_SPSR_FIQ);
        end
        return s;
    endfunction

    function automatic t_out_item apply_access(input t_in_item a);
        t_out_item   r;
        logic [4:0]  mode;
        logic [31:0] old;
        int          slot;
        int          sp;
        r    = '0;
        mode = bank[STATUS_SLOT][4:0];
        slot = bank_slot(mode, a.reg_index);
        case (a.kind)
            K_READ: begin
                r.read_data = bank[slot];
            end
            K_WRITE: begin
                bank[slot] = a.value;
            end
            K_INCR: begin
                old = bank[slot];
                bank[slot] = old + a.value;
                r.read_data = a.post_increment ? old : bank[slot];
            end
            K_SET_MODE: begin
                sp = saved_index(a.new_mode);
                if (a.save_status && sp >= 0) begin
                    bank[sp] = bank[STATUS_SLOT];
                end
                bank[STATUS_SLOT][4:0] = a.new_mode;
            end
            K_REVERT: begin
                sp = saved_index(mode);
                if (sp >= 0) begin
                    bank[STATUS_SLOT] = bank[sp];
                end
            end
            K_SET_FLAGS: begin
                bank[STATUS_SLOT][31:28] = {a.flag_n, a.flag_z, a.flag_c, a.flag_v};
            end
            K_WR_STATUS: begin
                bank[STATUS_SLOT] = a.value;
            end
            K_RD_SAVED: begin
                sp = saved_index(mode);
                if (sp >= 0) begin
                    r.read_data = bank[sp];
                end
            end
            K_RESET: begin
                clear_bank(a.value);
            end
            default: begin
            end
        endcase
        r.status_word  = bank[STATUS_SLOT];
        r.fiq_disabled = bank[STATUS_SLOT][6];
        r.irq_disabled = bank[STATUS_SLOT][7];
        return r;
    endfunction

    function automatic void add_row(input logic [3:0] k, input logic [3:0] r,
                                    input logic [31:0] v, input logic [4:0] m,
                                    input bit sv, input bit post, input logic [3:0] nzcv,
                                    input bit typed, input logic [31:0] rd,
                                    input logic [31:0] st);
        t_directed_row row;
        row.beat = {k, r, v, m, sv, post, nzcv};
        row.typed = typed;
        row.want.read_data    = rd;
        row.want.status_word  = st;
        row.want.fiq_disabled = st[6];
        row.want.irq_disabled = st[7];
        directed_rows.push_back(row);
    endfunction

    function automatic logic [4:0] pick_mode();
        logic [4:0] m;
        case ($urandom_range(0, 4))
            0: m = FIQ_MODE;
            1: m = IRQ_MODE;
            2: m = SVC_MODE;
            3: m = SYS_MODE;
            default: m = 5'($urandom);
        endcase
        return m;
    endfunction

    function automatic t_in_item random_access();
        t_in_item    a;
        logic [63:0] raw;
        int unsigned sel;
        raw = {$urandom, $urandom};
        a = raw[$bits(t_in_item)-1:0];
        case ($urandom_range(0, 5))
            0: a.value = '0;
            1: a.value = '1;
            2: a.value = 32'($urandom_range(0, 64));
            default: a.value = $urandom;
        endcase
        if ($urandom_range(0, 1) == 0) begin
            a.reg_index = 4'($urandom_range(8, 15));
        end
        a.new_mode = pick_mode();
        sel = $urandom_range(0, 99);
        if (sel < 22) begin
            a.kind = K_READ;
        end else if (sel < 40) begin
            a.kind = K_WRITE;
        end else if (sel < 55) begin
            a.kind = K_INCR;
        end else if (sel < 65) begin
            a.kind = K_SET_MODE;
        end else if (sel < 72) begin
            a.kind = K_REVERT;
        end else if (sel < 78) begin
            a.kind = K_SET_FLAGS;
        end else if (sel < 84) begin
            a.kind = K_WR_STATUS;
            if ($urandom_range(0, 9) < 7) begin
                a.value[4:0] = pick_mode();
            end
        end else if (sel < 91) begin
            a.kind = K_RD_SAVED;
        end else if (sel < 93) begin
            a.kind = K_RESET;
        end else if (sel < 96) begin
            a.kind = 4'($urandom_range(32'(K_SPARE_LO), 32'(K_SPARE_HI)));
        end else begin
            a.kind = 4'($urandom);
        end
        return a;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic send_beat(input t_in_item beat, input bit typed, input t_out_item want);
        int unsigned gap;
        t_out_item   predicted;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
        predicted = apply_access(beat);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected beat", o_out_data.status_word, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.read_data !== want.read_data) begin
                    flag_mismatch("read_data", o_out_data.read_data, want.read_data);
                end
                if (o_out_data.status_word !== want.status_word) begin
                    flag_mismatch("status_word", o_out_data.status_word, want.status_word);
                end
                if (o_out_data.fiq_disabled !== want.fiq_disabled) begin
                    flag_mismatch("fiq_disabled", 32'(o_out_data.fiq_disabled),
                                  32'(want.fiq_disabled));
                end
                if (o_out_data.irq_disabled !== want.irq_disabled) begin
                    flag_mismatch("irq_disabled", 32'(o_out_data.irq_disabled),
                                  32'(want.irq_disabled));
                end
            end
        end
    end

    initial begin
        int unsigned stall;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (o_out_valid !== 1'b1);
        end
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_out_item none;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        mismatches = 0;
        calm       = 1'b0;
        none       = '0;
        clear_bank('0);

        add_row(K_READ, 4'd13, '0, '0, 0, 0, 4'h0, 1, 32'h0000_7000, 32'h1F);
        add_row(K_WRITE, 4'd0, 32'hFFFF_FFFF, '0, 0, 0, 4'h0, 1, '0, 32'h1F);
        add_row(K_INCR, 4'd0, 32'h1, '0, 0, 1, 4'h0, 1, 32'hFFFF_FFFF, 32'h1F);
        add_row(K_INCR, 4'd0, 32'hFFFF_FFFF, '0, 0, 0, 4'h0, 1, 32'hFFFF_FFFF, 32'h1F);
        add_row(K_RD_SAVED, 4'd0, '0, '0, 0, 0, 4'h0, 1, '0, 32'h1F);
        add_row(K_REVERT, 4'd0, '0, '0, 0, 0, 4'h0, 1, '0, 32'h1F);
        add_row(K_SET_MODE, 4'd0, '0, SVC_MODE, 1, 0, 4'h0, 1, '0, 32'h13);
        add_row(K_WRITE, 4'd13, 32'h0000_1234, '0, 0, 0, 4'h0, 0, '0, '0);
        add_row(K_RD_SAVED, 4'd0, '0, '0, 0, 0, 4'h0, 1, 32'h1F, 32'h13);
        add_row(K_SET_MODE, 4'd0, '0, FIQ_MODE, 1, 0, 4'h0, 1, '0, 32'h11);
        add_row(K_WRITE, 4'd8, 32'hA5A5_A5A5, '0, 0, 0, 4'h0, 0, '0, '0);
        add_row(K_READ, 4'd14, '0, '0, 0, 0, 4'h0, 0, '0, '0);
        add_row(K_SET_FLAGS, 4'd0, '0, '0, 0, 0, 4'hF, 1, '0, 32'hF000_0011);
        add_row(K_SET_MODE, 4'd0, '0, IRQ_MODE, 1, 0, 4'h0, 1, '0, 32'hF000_0012);
        add_row(K_INCR, 4'd13, 32'h10, '0, 0, 0, 4'h0, 0, '0, '0);
        add_row(K_REVERT, 4'd0, '0, '0, 0, 0, 4'h0, 1, '0, 32'hF000_0011);
        add_row(K_REVERT, 4'd0, '0, '0, 0, 0, 4'h0, 1, '0, 32'h13);
        add_row(K_SET_MODE, 4'd0, '0, 5'h00, 1, 0, 4'h0, 0, '0, '0);
        add_row(K_READ, 4'd13, '0, '0, 0, 0, 4'h0, 0, '0, '0);
        add_row(K_WR_STATUS, 4'd0, 32'hFFFF_FFFF, '0, 0, 0, 4'h0, 1, '0, 32'hFFFF_FFFF);
        add_row(K_SET_FLAGS, 4'd0, '0, '0, 0, 0, 4'h0, 1, '0, 32'h0FFF_FFFF);
        add_row(K_SPARE_HI, 4'd15, 32'hFFFF_FFFF, 5'h1F, 1, 1, 4'hF, 0, '0, '0);
        add_row(K_SPARE_LO, 4'd1, 32'h5555_5555, 5'h0A, 0, 0, 4'h5, 0, '0, '0);
        add_row(K_RESET, 4'd0, 32'hFFFF_FFFC, '0, 0, 0, 4'h0, 1, '0, 32'h1F);
        add_row(K_READ, 4'd15, '0, '0, 0, 0, 4'h0, 0, '0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        end
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            calm = (n % 150) >= 110;
            send_beat(random_access(), 1'b0, none);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
